// File: hw/rtl/mpfs_pkg.sv
// Shared types, geometry constants and codes for the mono framebuffer scaler.
`timescale 1ns / 1ps

package mpfs_pkg;

   // Screen and source geometry
   localparam int SCREEN_WIDTH  = 320;
   localparam int SCREEN_HEIGHT = 240;
   localparam int SIDE_INSET    = 4;
   localparam int SOURCE_WIDTH  = 128;
   localparam int SOURCE_HEIGHT = 64;

   localparam int STORE_DEPTH = 1024;
   localparam int ADDR_W      = 10;
   localparam int BYTE_W      = 8;
   localparam int X_W         = 9;
   localparam int Y_W         = 8;
   localparam int COLOR_W     = 16;
   localparam int COORD_W     = 12;

   // Aspect fit, worked out at elaboration
   localparam int USABLE       = SCREEN_WIDTH - 2 * SIDE_INSET;
   localparam bit FIT_BY_WIDTH =
      (USABLE * SOURCE_HEIGHT) <= (SCREEN_HEIGHT * SOURCE_WIDTH);
   localparam int FIT_W = (USABLE <= 0) ? 0 :
      (FIT_BY_WIDTH ? USABLE : (SCREEN_HEIGHT * SOURCE_WIDTH) / SOURCE_HEIGHT);
   localparam int FIT_H = (USABLE <= 0) ? 0 :
      (FIT_BY_WIDTH ? (USABLE * SOURCE_HEIGHT) / SOURCE_WIDTH : SCREEN_HEIGHT);
   localparam int OFF_X = (SCREEN_WIDTH - FIT_W) / 2;
   localparam int OFF_Y = (SCREEN_HEIGHT - FIT_H) / 2;
   localparam bit FIT_OK = (FIT_W > 0) && (FIT_H > 0);
   localparam int FIT_W_DIV = (FIT_W > 0) ? FIT_W : 1;
   localparam int FIT_H_DIV = (FIT_H > 0) ? FIT_H : 1;

   // Offsets into the image and source coordinates
   localparam int DX_W = $clog2(SCREEN_WIDTH);
   localparam int DY_W = $clog2(SCREEN_HEIGHT);
   localparam int SX_W = $clog2(SOURCE_WIDTH);
   localparam int SY_W = $clog2(SOURCE_HEIGHT);

   // Reciprocal scaling: q0 = (d * C) >> K is the quotient or one below it
   localparam int KX   = $clog2(SCREEN_WIDTH * SOURCE_WIDTH);
   localparam int KY   = $clog2(SCREEN_HEIGHT * SOURCE_HEIGHT);
   localparam int RX   = (1 << KX) / FIT_W_DIV;
   localparam int RY   = (1 << KY) / FIT_H_DIV;
   localparam int CX_W = SX_W + KX + 1;
   localparam int CY_W = SY_W + KY + 1;
   localparam logic [CX_W-1:0] CX = CX_W'(SOURCE_WIDTH * RX);
   localparam logic [CY_W-1:0] CY = CY_W'(SOURCE_HEIGHT * RY);
   localparam int NX_W = KX + 1;
   localparam int NY_W = KY + 1;

   // Byte index into the store
   localparam int IDX_W =
      ((SX_W + SY_W) > ADDR_W ? (SX_W + SY_W) : ADDR_W) + 1;
   localparam int PAGE_SHIFT = 3;
   localparam logic [2:0] PAGE_ROW_MASK = 3'h7;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef enum logic [0:0] {
      OP_WRITE = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   typedef enum logic [0:0] {
      CSR_CLEAR_COLOR = 1'b0,
      CSR_SET_COLOR   = 1'b1
   } csr_index_type;

   typedef struct packed {
      op_type              operation;
      logic [ADDR_W-1:0]   fb_address;
      logic [BYTE_W-1:0]   fb_byte;
      logic [X_W-1:0]      screen_x;
      logic [Y_W-1:0]      screen_y;
   } req_word_type;

   typedef struct packed {
      logic [COLOR_W-1:0]  pixel_color;
      logic                in_image;
   } rsp_word_type;

   // Classified word passed from front to back
   typedef struct packed {
      op_type              operation;
      logic                in_image;
      logic [DX_W-1:0]     dx;
      logic [DY_W-1:0]     dy;
      logic [ADDR_W-1:0]   fb_address;
      logic [BYTE_W-1:0]   fb_byte;
   } entry_type;

   typedef struct packed {
      logic [COLOR_W-1:0]  clear_color;
      logic [COLOR_W-1:0]  set_color;
   } color_cfg_type;

endpackage

// File: hw/rtl/mpfs_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps

module mpfs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/mpfs_front.sv
// Front stage: takes request words and classifies queries against the image area.
`timescale 1ns / 1ps

module mpfs_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  mpfs_pkg::req_word_type req_word,
   output logic                  out_valid,
   input  logic                  out_ready,
   output mpfs_pkg::entry_type   out_entry
);
   import mpfs_pkg::*;

   logic       valid_ff, valid_in;
   entry_type  entry_ff, entry_in;

   logic [COORD_W-1:0] x_ext, y_ext, x_rel, y_rel;
   logic               x_hit, y_hit;

   assign req_ready = !valid_ff || out_ready;

   always_comb begin
      x_ext = COORD_W'(req_word.screen_x);
      y_ext = COORD_W'(req_word.screen_y);
      x_rel = x_ext - COORD_W'(OFF_X);
      y_rel = y_ext - COORD_W'(OFF_Y);
      x_hit = (x_ext < COORD_W'(SCREEN_WIDTH)) && (x_ext >= COORD_W'(OFF_X)) &&
              (x_rel < COORD_W'(FIT_W));
      y_hit = (y_ext < COORD_W'(SCREEN_HEIGHT)) && (y_ext >= COORD_W'(OFF_Y)) &&
              (y_rel < COORD_W'(FIT_H));

      entry_in.operation  = req_word.operation;
      entry_in.in_image   = FIT_OK && x_hit && y_hit;
      entry_in.dx         = x_rel[DX_W-1:0];
      entry_in.dy         = y_rel[DY_W-1:0];
      entry_in.fb_address = req_word.fb_address;
      entry_in.fb_byte    = req_word.fb_byte;

      valid_in = valid_ff;
      if (req_ready) begin
         valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_ready && req_valid) begin
         entry_ff <= entry_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_entry = entry_ff;

endmodule

// File: hw/rtl/mpfs_queue.sv
// Short word queue between the front and back stages.
`timescale 1ns / 1ps

module mpfs_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  mpfs_pkg::entry_type push_entry,
   output logic                pop_valid,
   input  logic                pop_ready,
   output mpfs_pkg::entry_type pop_entry
);
   import mpfs_pkg::*;

   entry_type         slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              do_push, do_pop;

   assign push_ready = count_ff < (QPTR_W + 1)'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_entry  = slot_ff[rd_ptr_ff];

   always_comb begin
      do_push   = push_valid && push_ready;
      do_pop    = pop_valid && pop_ready;
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: hw/rtl/mpfs_back.sv
// Back pipeline: nearest-neighbor scaling, framebuffer access and color select.
`timescale 1ns / 1ps

module mpfs_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  mpfs_pkg::entry_type     in_entry,
   input  mpfs_pkg::color_cfg_type colors,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output mpfs_pkg::rsp_word_type  rsp_word
);
   import mpfs_pkg::*;

   // Stage valids: a popped word, b coarse quotient, c products, d source pixel,
   // f framebuffer data
   logic a_v_ff, b_v_ff, c_v_ff, d_v_ff, f_v_ff;
   logic advance;

   entry_type a_ff, b_ff, c_ff, d_ff;

   logic [DX_W+CX_W-1:0] prod_x;
   logic [DY_W+CY_W-1:0] prod_y;
   logic [SX_W-1:0]      qx_in, b_qx_ff, c_qx_ff, sx_in, d_sx_ff;
   logic [SY_W-1:0]      qy_in, b_qy_ff, c_qy_ff, sy_in, d_sy_ff;
   logic [NX_W-1:0]      px_in, nx_in, c_px_ff, c_nx_ff;
   logic [NY_W-1:0]      py_in, ny_in, c_py_ff, c_ny_ff;

   logic [IDX_W-1:0]     idx;
   logic                 in_store;
   logic                 ram_wr, ram_rd;
   logic [ADDR_W-1:0]    ram_addr;
   logic [BYTE_W-1:0]    ram_data;

   logic                 f_op_query_ff, f_in_image_ff, f_in_store_ff;
   logic [2:0]           f_bit_ff;
   logic                 pix_on;

   // The whole pipe holds while a finished result waits
   assign advance  = !(f_v_ff && f_op_query_ff && !rsp_ready);
   assign in_ready = advance;

   always_comb begin
      prod_x = (DX_W + CX_W)'(a_ff.dx) * (DX_W + CX_W)'(CX);
      prod_y = (DY_W + CY_W)'(a_ff.dy) * (DY_W + CY_W)'(CY);
      qx_in  = SX_W'(prod_x >> KX);
      qy_in  = SY_W'(prod_y >> KY);

      px_in = NX_W'(b_qx_ff) * NX_W'(FIT_W_DIV);
      py_in = NY_W'(b_qy_ff) * NY_W'(FIT_H_DIV);
      nx_in = NX_W'(b_ff.dx) * NX_W'(SOURCE_WIDTH);
      ny_in = NY_W'(b_ff.dy) * NY_W'(SOURCE_HEIGHT);

      // coarse quotient may be one low
      sx_in = ((c_px_ff + NX_W'(FIT_W_DIV)) <= c_nx_ff) ? c_qx_ff + 1'b1 : c_qx_ff;
      sy_in = ((c_py_ff + NY_W'(FIT_H_DIV)) <= c_ny_ff) ? c_qy_ff + 1'b1 : c_qy_ff;

      idx = IDX_W'(d_sy_ff >> PAGE_SHIFT) * IDX_W'(SOURCE_WIDTH) + IDX_W'(d_sx_ff);
      in_store = idx < IDX_W'(STORE_DEPTH);

      ram_wr   = advance && d_v_ff && (d_ff.operation == OP_WRITE);
      ram_rd   = advance && d_v_ff && (d_ff.operation == OP_QUERY);
      ram_addr = (d_ff.operation == OP_WRITE) ? d_ff.fb_address : idx[ADDR_W-1:0];
   end

   mpfs_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (STORE_DEPTH)
   ) u_frame_store (
      .clock   (clock),
      .wr_en   (ram_wr),
      .rd_en   (ram_rd),
      .addr    (ram_addr),
      .wr_data (d_ff.fb_byte),
      .rd_data (ram_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
         d_v_ff <= 1'b0;
         f_v_ff <= 1'b0;
      end else if (advance) begin
         a_v_ff <= in_valid;
         b_v_ff <= a_v_ff;
         c_v_ff <= b_v_ff;
         d_v_ff <= c_v_ff;
         f_v_ff <= d_v_ff;
      end
      if (advance) begin
         a_ff          <= in_entry;
         b_ff          <= a_ff;
         b_qx_ff       <= qx_in;
         b_qy_ff       <= qy_in;
         c_ff          <= b_ff;
         c_qx_ff       <= b_qx_ff;
         c_qy_ff       <= b_qy_ff;
         c_px_ff       <= px_in;
         c_py_ff       <= py_in;
         c_nx_ff       <= nx_in;
         c_ny_ff       <= ny_in;
         d_ff          <= c_ff;
         d_sx_ff       <= sx_in;
         d_sy_ff       <= sy_in;
         f_op_query_ff <= d_ff.operation == OP_QUERY;
         f_in_image_ff <= d_ff.in_image;
         f_in_store_ff <= in_store;
         f_bit_ff      <= 3'(d_sy_ff) & PAGE_ROW_MASK;
      end
   end

   always_comb begin
      pix_on = f_in_image_ff && f_in_store_ff && ram_data[f_bit_ff];
      rsp_word.pixel_color = pix_on ? colors.set_color : colors.clear_color;
      rsp_word.in_image    = f_in_image_ff;
   end

   assign rsp_valid = f_v_ff && f_op_query_ff;

endmodule

// File: hw/rtl/mono_page_fb_scaler_rgb565.sv
// Top level of the page-layout mono framebuffer to RGB565 nearest-neighbor scaler.
//
//   channel  direction  handshake            word
//   req      in         req_valid/req_ready  req_word: operation, fb_address, fb_byte,
//                                            screen_x, screen_y
//   rsp      out        rsp_valid/rsp_ready  rsp_word: pixel_color, in_image
//   csr      in         csr_wr_en            csr_index, csr_wdata (no wait, no read)
//
// One word accepted per clock while req_ready is high. Unstalled, a query passes seven
// registers (front, one queue slot, four scaling stages, framebuffer read), the first
// loaded at the accepting edge.
// Writes give no response and pass through the same pipe, so order is kept.
// While rsp_ready is low with a response waiting the back pipe holds; the queue
// (four words) and front keep taking words until the queue fills.
// Synchronous reset clears control state and restores the colors to their reset
// values; the framebuffer is not cleared.
`timescale 1ns / 1ps

module mono_page_fb_scaler_rgb565 (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  mpfs_pkg::req_word_type          req_word,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output mpfs_pkg::rsp_word_type          rsp_word,
   input  logic                            csr_wr_en,
   input  mpfs_pkg::csr_index_type         csr_index,
   input  logic [mpfs_pkg::COLOR_W-1:0]    csr_wdata
);
   import mpfs_pkg::*;

   color_cfg_type colors_ff, colors_in;

   logic      front_valid, front_ready;
   entry_type front_entry;
   logic      queue_valid, queue_ready;
   entry_type queue_entry;

   always_comb begin
      colors_in = colors_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_CLEAR_COLOR: colors_in.clear_color = csr_wdata;
            CSR_SET_COLOR:   colors_in.set_color   = csr_wdata;
            default:         colors_in = colors_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         colors_ff.clear_color <= '0;
         colors_ff.set_color   <= '1;
      end else begin
         colors_ff <= colors_in;
      end
   end

   mpfs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_entry (front_entry)
   );

   mpfs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_entry (front_entry),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready),
      .pop_entry  (queue_entry)
   );

   mpfs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (queue_valid),
      .in_ready  (queue_ready),
      .in_entry  (queue_entry),
      .colors    (colors_ff),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

endmodule

// File: sim/mono_page_fb_scaler_rgb565_tb.sv
// Self-checking bench for the mono page framebuffer to RGB565 scaler.
`timescale 1ns / 1ps

module mono_page_fb_scaler_rgb565_tb;
   import mpfs_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 20;
   localparam int PHASE_COUNT = 6;
   localparam int PHASE_WORDS = 160;
   localparam int ROW_MASK = 7;

   // Mirror of the framebuffer plus the queue of pixels still owed by the block.
   class pixel_scoreboard;
      logic [BYTE_W-1:0]  fb_mirror [STORE_DEPTH];
      bit                 fb_loaded [STORE_DEPTH];
      logic [COLOR_W-1:0] clear_rgb;
      logic [COLOR_W-1:0] set_rgb;
      rsp_word_type       pixel_queue [$];
      int                 fit_w;
      int                 fit_h;
      int                 off_x;
      int                 off_y;
      int                 errors;

      function new();
         int usable;
         usable = SCREEN_WIDTH - 2 * SIDE_INSET;
         if (usable <= 0) begin
            fit_w = 0;
            fit_h = 0;
         end else if (usable * SOURCE_HEIGHT <= SCREEN_HEIGHT * SOURCE_WIDTH) begin
            fit_w = usable;
            fit_h = (usable * SOURCE_HEIGHT) / SOURCE_WIDTH;
         end else begin
            fit_h = SCREEN_HEIGHT;
            fit_w = (SCREEN_HEIGHT * SOURCE_WIDTH) / SOURCE_HEIGHT;
         end
         off_x = (SCREEN_WIDTH - fit_w) / 2;
         off_y = (SCREEN_HEIGHT - fit_h) / 2;
         clear_rgb = '0;
         set_rgb = '1;
         errors = 0;
         foreach (fb_loaded[i]) fb_loaded[i] = 1'b0;
      endfunction

      // Maps a screen pixel to its source byte and bit; 0 means margin or off-screen.
      function bit locate(input int x, input int y, output int idx, output int row_bit);
         int dx;
         int dy;
         int sx;
         int sy;
         dx = x - off_x;
         dy = y - off_y;
         idx = 0;
         row_bit = 0;
         if (fit_w <= 0 || fit_h <= 0 || x >= SCREEN_WIDTH || y >= SCREEN_HEIGHT ||
             dx < 0 || dy < 0 || dx >= fit_w || dy >= fit_h)
            return 1'b0;
         sx = (dx * SOURCE_WIDTH) / fit_w;
         sy = (dy * SOURCE_HEIGHT) / fit_h;
         idx = (sy >> 3) * SOURCE_WIDTH + sx;
         row_bit = sy & ROW_MASK;
         return 1'b1;
      endfunction

      function void note_word(input req_word_type w);
         rsp_word_type px;
         int idx;
         int row_bit;
         logic [BYTE_W-1:0] src;
         if (w.operation == OP_WRITE) begin
            fb_mirror[w.fb_address] = w.fb_byte;
            fb_loaded[w.fb_address] = 1'b1;
         end else begin
            px.in_image = locate(int'(w.screen_x), int'(w.screen_y), idx, row_bit);
            src = '0;
            if (px.in_image && idx < STORE_DEPTH) src = fb_mirror[idx];
            px.pixel_color = (px.in_image && src[row_bit]) ? set_rgb : clear_rgb;
            pixel_queue.push_back(px);
         end
      endfunction

      function void check_pixel(input rsp_word_type got);
         rsp_word_type want;
         if (pixel_queue.size() == 0) begin
            $error("unexpected rsp word: pixel_color %h in_image %b",
                   got.pixel_color, got.in_image);
            errors++;
            return;
         end
         want = pixel_queue.pop_front();
         if (got.pixel_color !== want.pixel_color) begin
            $error("pixel_color mismatch: expected %h actual %h",
                   want.pixel_color, got.pixel_color);
            errors++;
         end
         if (got.in_image !== want.in_image) begin
            $error("in_image mismatch: expected %b actual %b", want.in_image, got.in_image);
            errors++;
         end
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   req_word_type        req_word = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   rsp_word_type        rsp_word;
   logic                csr_wr_en = 1'b0;
   csr_index_type       csr_index = CSR_CLEAR_COLOR;
   logic [COLOR_W-1:0]  csr_wdata = '0;

   pixel_scoreboard     bench;
   int                  send_idle_pct = 0;
   int                  recv_stall_pct = 0;
   int                  cycle_count = 0;

   mono_page_fb_scaler_rgb565 u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("mono_page_fb_scaler_rgb565 regression: fail");
         $finish;
      end
   end

   // Result side: check on accept, then pick the next ready value.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) bench.check_pixel(rsp_word);
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   function automatic req_word_type random_word(input op_type op);
      req_word_type w;
      w.operation = op;
      w.fb_address = ADDR_W'($urandom_range(STORE_DEPTH - 1));
      w.fb_byte = BYTE_W'($urandom_range(255));
      w.screen_x = X_W'($urandom_range((1 << X_W) - 1));
      w.screen_y = Y_W'($urandom_range((1 << Y_W) - 1));
      return w;
   endfunction

   task automatic send_word(input req_word_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (req_ready !== 1'b1);
      bench.note_word(w);
   endtask

   task automatic send_write(input int addr, input int data);
      req_word_type w;
      w = random_word(OP_WRITE);
      w.fb_address = ADDR_W'(addr);
      w.fb_byte = BYTE_W'(data);
      send_word(w);
   endtask

   // Loads the source byte first when the pixel hits one never written.
   task automatic send_query(input int x, input int y);
      req_word_type w;
      int idx;
      int row_bit;
      if (bench.locate(x, y, idx, row_bit) && idx < STORE_DEPTH && !bench.fb_loaded[idx])
         send_write(idx, $urandom_range(255));
      w = random_word(OP_QUERY);
      w.screen_x = X_W'(x);
      w.screen_y = Y_W'(y);
      send_word(w);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (bench.pixel_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_colors(input logic [COLOR_W-1:0] clear_rgb,
                             input logic [COLOR_W-1:0] set_rgb);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_CLEAR_COLOR;
      csr_wdata <= clear_rgb;
      @(posedge clock);
      csr_index <= CSR_SET_COLOR;
      csr_wdata <= set_rgb;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      bench.clear_rgb = clear_rgb;
      bench.set_rgb = set_rgb;
   endtask

   initial begin
      int p;
      int n;
      int pick;
      int x;
      int y;
      int x_end;
      int y_end;
      logic [COLOR_W-1:0] c_clear;
      logic [COLOR_W-1:0] c_set;

      bench = new();
      x_end = bench.off_x + bench.fit_w - 1;
      y_end = bench.off_y + bench.fit_h - 1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset colors, image corners, margins, off-screen, overwrite.
      send_write(0, 8'h01);
      send_write(STORE_DEPTH - 1, 8'h80);
      send_query(bench.off_x, bench.off_y);
      send_query(x_end, y_end);
      send_query(bench.off_x - 1, bench.off_y);
      send_query(x_end + 1, bench.off_y);
      send_query(bench.off_x, bench.off_y - 1);
      send_query(bench.off_x, y_end + 1);
      send_query(0, 0);
      send_query(SCREEN_WIDTH, 100);
      send_query(0, SCREEN_HEIGHT);
      send_query((1 << X_W) - 1, (1 << Y_W) - 1);
      send_write(0, 8'h00);
      send_query(bench.off_x, bench.off_y);
      send_write(STORE_DEPTH - 1, 8'hFF);
      send_query(x_end, y_end);
      send_query(x_end, bench.off_y);
      send_query(bench.off_x, y_end);
      send_query(SCREEN_WIDTH / 2, SCREEN_HEIGHT / 2);
      drain();

      for (p = 0; p < PHASE_COUNT; p++) begin
         case (p)
            0: begin c_clear = 16'h0000; c_set = 16'hFFFF; end
            1: begin c_clear = 16'hFFFF; c_set = 16'h0000; end
            4: begin c_clear = 16'hF800; c_set = 16'h07E0; end
            default: begin
               c_clear = COLOR_W'($urandom_range(16'hFFFF));
               c_set = COLOR_W'($urandom_range(16'hFFFF));
            end
         endcase
         set_colors(c_clear, c_set);
         case (p % 4)
            0: begin send_idle_pct = 0; recv_stall_pct = 0; end
            1: begin send_idle_pct = 70; recv_stall_pct = 0; end
            2: begin send_idle_pct = 0; recv_stall_pct = 70; end
            default: begin send_idle_pct = 27; recv_stall_pct = 27; end
         endcase

         for (n = 0; n < PHASE_WORDS; n++) begin
            // hold off until the block has answered everything
            if (p == 2 && n == PHASE_WORDS / 2) drain();
            if ($urandom_range(99) < 35) begin
               send_write($urandom_range(STORE_DEPTH - 1), $urandom_range(255));
            end else begin
               pick = $urandom_range(99);
               if (pick < 75) begin
                  x = $urandom_range(x_end, bench.off_x);
                  y = $urandom_range(y_end, bench.off_y);
               end else if (pick < 90) begin
                  x = $urandom_range(SCREEN_WIDTH - 1);
                  y = $urandom_range(SCREEN_HEIGHT - 1);
               end else begin
                  x = $urandom_range((1 << X_W) - 1);
                  y = $urandom_range((1 << Y_W) - 1);
               end
               send_query(x, y);
            end
         end
         drain();
      end

      if (bench.errors == 0)
         $display("mono_page_fb_scaler_rgb565 regression: pass");
      else
         $display("mono_page_fb_scaler_rgb565 regression: fail");
      $finish;
   end

endmodule
